>>> hw/rtl/smdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smdm_pkg
// shared constants and types for the sign matrix determinant block
// ----------------------------------------------------------------------------
package smdm_pkg;

  localparam int unsigned MaxOrder     = 7;
  localparam int unsigned PatternWidth = 49;
  localparam int unsigned DetWidth     = 11;
  localparam int unsigned EntryWidth   = 12;
  localparam int unsigned OrderWidth   = 3;
  localparam logic [OrderWidth-1:0] OrderReset = 3'd4;

  // config register indexes
  localparam logic [0:0] RegMatrixOrder = 1'b0;

  typedef logic signed [EntryWidth-1:0] entry_t;

endpackage

>>> hw/rtl/smdm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smdm_divider
// restoring signed divider, one quotient bit per cycle, exact division
// ----------------------------------------------------------------------------
module smdm_divider import smdm_pkg::*; #(
  parameter int unsigned NumWidth = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [NumWidth-1:0] num_i,
  input  entry_t                     den_i,
  output logic                       done_o,
  output entry_t                     quot_o
);

  localparam int unsigned CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0]   rem_q, rem_d;
  logic [NumWidth-1:0]   quo_q, quo_d;
  logic [EntryWidth-1:0] den_q, den_d;
  logic                  neg_q, neg_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [NumWidth:0]     shifted;
  logic [NumWidth-1:0]   num_abs;
  logic [NumWidth-1:0]   quo_sgn;

  assign num_abs = num_i[NumWidth-1] ? NumWidth'(-num_i) : NumWidth'(num_i);
  assign shifted = {rem_q, quo_q[NumWidth-1]};
  assign quo_sgn = neg_q ? NumWidth'(-quo_q) : quo_q;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_abs;
      den_d  = den_i[EntryWidth-1] ? EntryWidth'(-den_i) : EntryWidth'(den_i);
      neg_d  = num_i[NumWidth-1] ^ den_i[EntryWidth-1];
      cnt_d  = CntWidth'(NumWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {{(NumWidth+1-EntryWidth){1'b0}}, den_q}) begin
        rem_d = NumWidth'(shifted - {{(NumWidth+1-EntryWidth){1'b0}}, den_q});
        quo_d = {quo_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted[NumWidth-1:0];
        quo_d = {quo_q[NumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = entry_t'(quo_sgn[EntryWidth-1:0]);

endmodule

>>> hw/rtl/sign_matrix_determinant_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_matrix_determinant_max
// exact determinant of a +-1 matrix with a running maximum
// ----------------------------------------------------------------------------
// Usage: each s_axis transaction carries one sign pattern (bit i*n+j set
// means +1). The block fills n*n entries of a 49-entry work memory, then
// runs fraction-free elimination one entry at a time: read three memory
// words, multiply and subtract, divide exactly by the previous pivot in a
// bit-serial divider, write back. Each m_axis transaction returns the
// determinant, the largest determinant since reset and a flag for a new
// maximum. Each updated entry takes three reads, a divider start and a
// pass through the divider; a row swap reads and writes every column of
// both rows. The divider sets the pace.
// One item is worked at a time; s_axis_tready is high only while idle.
// A finished result sits in the output register until m_axis_tready; the
// next item is already accepted then, and waits before its result only if
// the previous result has not been taken.
// Reset clears the maximum to -1024 and matrix_order to 4. The work memory
// needs no clearing since every entry is written before it is read.
module sign_matrix_determinant_max import smdm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [55:0]               s_axis_tdata,  // [48:0] sign_pattern
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [10:0] determinant, [21:11] best_determinant, [22] is_new_best
  output logic [23:0]               m_axis_tdata,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned Depth   = MaxOrder * MaxOrder;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned IdxW    = $clog2(MaxOrder + 1);
  localparam int unsigned ProdW   = 2 * EntryWidth;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StFill  = 4'd1;
  localparam logic [3:0] StPiv   = 4'd2;
  localparam logic [3:0] StSrch  = 4'd3;
  localparam logic [3:0] StSwRd  = 4'd4;
  localparam logic [3:0] StSwWr  = 4'd5;
  localparam logic [3:0] StRdA   = 4'd6;
  localparam logic [3:0] StRdB   = 4'd7;
  localparam logic [3:0] StMul   = 4'd8;
  localparam logic [3:0] StDiv   = 4'd9;
  localparam logic [3:0] StOut   = 4'd11;
  localparam logic [3:0] StRdC   = 4'd12;
  localparam logic [3:0] StRdD   = 4'd13;

  // config
  logic [OrderWidth-1:0] order_q;
  logic                  cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == RegMatrixOrder) & (paddr[1:0] == 2'b00);
  assign prdata = (paddr == 3'd0) ? {{(32-OrderWidth){1'b0}}, order_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
    end else if (cfg_wr) begin
      order_q <= pwdata[OrderWidth-1:0];
    end
  end

  // work memory
  entry_t             mem [Depth];
  logic               mem_we;
  logic [AddrW-1:0]   mem_wa, mem_ra;
  entry_t             mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  // control
  logic [3:0]             st_q, st_d;
  logic [IdxW-1:0]        n_q, n_d, k_q, k_d, i_q, i_d, j_q, j_d, r_q, r_d;
  logic [PatternWidth-1:0] pat_q, pat_d;
  logic [5:0]             bit_q, bit_d;
  entry_t                 piv_q, piv_d, prev_q, prev_d, lead_q, lead_d;
  entry_t                 a_q, a_d, tmp_q, tmp_d;
  logic                   neg_q, neg_d;
  logic signed [ProdW-1:0] num_q, num_d;
  logic                   div_start, div_done;
  entry_t                 div_q;
  logic [DetWidth-1:0]    det_q, det_d, best_q, best_d, odet_q, obest_q;
  logic                   fresh_q, ovalid_q, ovalid_d;
  logic                   oload;
  logic [DetWidth-1:0]    det_res;
  logic                   fresh_c;

  function automatic logic [AddrW-1:0] addr(input logic [IdxW-1:0] row,
                                            input logic [IdxW-1:0] col);
    addr = AddrW'(row * MaxOrder + col);
  endfunction

  smdm_divider #(.NumWidth(ProdW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_q), .den_i(prev_q),
    .done_o(div_done), .quot_o(div_q)
  );

  assign s_axis_tready = (st_q == StIdle);
  assign fresh_c = $signed(det_q) > $signed(best_q);

  always_comb begin
    st_d = st_q; n_d = n_q; k_d = k_q; i_d = i_q; j_d = j_q; r_d = r_q;
    pat_d = pat_q; bit_d = bit_q; piv_d = piv_q; prev_d = prev_q;
    lead_d = lead_q; a_d = a_q; tmp_d = tmp_q; neg_d = neg_q; num_d = num_q;
    det_d = det_q; best_d = best_q; ovalid_d = ovalid_q;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
    div_start = 1'b0; oload = 1'b0;
    // last entry comes straight from the divider, it is written this cycle
    det_res = neg_q ? DetWidth'(-div_q) : DetWidth'(div_q);
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          pat_d = s_axis_tdata[PatternWidth-1:0];
          n_d   = (order_q == '0) ? IdxW'(1) : IdxW'(order_q);
          i_d = '0; j_d = '0; bit_d = '0; neg_d = 1'b0; k_d = '0;
          prev_d = entry_t'(1);
          st_d = StFill;
        end
      end
      StFill: begin
        mem_we = 1'b1;
        mem_wa = addr(i_q, j_q);
        mem_wd = pat_q[bit_q] ? entry_t'(1) : entry_t'(-1);
        bit_d = bit_q + 1'b1;
        if (j_q == n_q - 1'b1) begin
          j_d = '0; i_d = i_q + 1'b1;
          if (i_q == n_q - 1'b1) begin
            mem_ra = addr(k_q, k_q);
            if (n_q == IdxW'(1)) begin
              // a 1 by 1 matrix is its own determinant
              det_d = DetWidth'(mem_wd);
              st_d  = StOut;
            end else st_d = StPiv;
          end
        end else j_d = j_q + 1'b1;
      end
      StPiv: begin
        // mem_rd_q holds (k,k)
        if (mem_rd_q != '0) begin
          piv_d = mem_rd_q; i_d = k_q + 1'b1; j_d = k_q + 1'b1;
          mem_ra = addr(k_q + 1'b1, k_q);
          st_d = StRdA;
        end else begin
          r_d = k_q + 1'b1;
          mem_ra = addr(k_q + 1'b1, k_q);
          st_d = StSrch;
        end
      end
      StSrch: begin
        if (r_q >= n_q) begin
          det_d = '0; st_d = StOut;
        end else if (mem_rd_q != '0) begin
          neg_d = ~neg_q; j_d = '0;
          mem_ra = addr(k_q, '0);
          st_d = StSwRd;
        end else begin
          r_d = r_q + 1'b1;
          mem_ra = addr(r_q + 1'b1, k_q);
        end
      end
      StSwRd: begin
        tmp_d = mem_rd_q;
        mem_ra = addr(r_q, j_q);
        st_d = StSwWr;
      end
      StSwWr: begin
        // write row k from row r this cycle, row r from tmp next via tmp path
        mem_we = 1'b1; mem_wa = addr(k_q, j_q); mem_wd = mem_rd_q;
        st_d = StRdC;
      end
      StRdC: begin
        mem_we = 1'b1; mem_wa = addr(r_q, j_q); mem_wd = tmp_q;
        if (j_q == n_q - 1'b1) begin
          mem_ra = addr(k_q, k_q);
          st_d = StPiv;
        end else begin
          j_d = j_q + 1'b1;
          mem_ra = addr(k_q, j_q + 1'b1);
          st_d = StSwRd;
        end
      end
      StRdA: begin
        // lead = (i,k)
        lead_d = mem_rd_q;
        mem_ra = addr(i_q, j_q);
        st_d = StRdB;
      end
      StRdB: begin
        a_d = mem_rd_q;
        mem_ra = addr(k_q, j_q);
        st_d = StRdD;
      end
      StRdD: begin
        num_d = ProdW'(piv_q * a_q) - ProdW'(lead_q * mem_rd_q);
        st_d = StMul;
      end
      StMul: begin
        div_start = 1'b1;
        st_d = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          mem_we = 1'b1; mem_wa = addr(i_q, j_q); mem_wd = div_q;
          if (j_q == n_q - 1'b1) begin
            if (i_q == n_q - 1'b1) begin
              prev_d = piv_q;
              k_d = k_q + 1'b1;
              if (k_q + 1'b1 == n_q - 1'b1) begin
                det_d = det_res;
                st_d = StOut;
              end else begin
                mem_ra = addr(k_q + 1'b1, k_q + 1'b1);
                st_d = StPiv;
              end
            end else begin
              i_d = i_q + 1'b1; j_d = k_q + 1'b1;
              mem_ra = addr(i_q + 1'b1, k_q);
              st_d = StRdA;
            end
          end else begin
            j_d = j_q + 1'b1;
            mem_ra = addr(i_q, k_q);
            st_d = StRdA;
          end
        end
      end
      StOut: begin
        if (!ovalid_q || m_axis_tready) begin
          oload = 1'b1; ovalid_d = 1'b1;
          if (fresh_c) best_d = det_q;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; best_q <= DetWidth'(-1024); ovalid_q <= 1'b0;
      neg_q <= 1'b0;
    end else begin
      st_q <= st_d; best_q <= best_d; ovalid_q <= ovalid_d; neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; k_q <= k_d; i_q <= i_d; j_q <= j_d; r_q <= r_d;
    pat_q <= pat_d; bit_q <= bit_d; piv_q <= piv_d; prev_q <= prev_d;
    lead_q <= lead_d; a_q <= a_d; tmp_q <= tmp_d; num_q <= num_d;
    det_q <= det_d;
    if (oload) begin
      odet_q  <= det_q;
      obest_q <= fresh_c ? det_q : best_q;
      fresh_q <= fresh_c;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, fresh_q, obest_q, odet_q};

endmodule

>>> hw/rtl/smdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smdm_checker
// port-level checks for the determinant block
// ----------------------------------------------------------------------------
module smdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a new best always reports itself as the best
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tdata[21:11] == m_axis_tdata[10:0])
    else $error("new best differs from determinant");

  // best never below this determinant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[21:11]) >= $signed(m_axis_tdata[10:0]))
    else $error("best below determinant");

  // an accepted item closes the input at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input reopened at once");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind sign_matrix_determinant_max smdm_checker u_smdm_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
